// File: src/rpnp_pkg.sv
// Package for the radix prefix number parser.
// Holds the radix and position codes and the control-state struct; no dependencies.
`default_nettype none

package rpnp_pkg;

    localparam int VALUE_W = 64;   // width of the result field
    localparam int CH_W    = 8;    // width of one character

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [CH_W-1:0] CH_EIGHT = 8'h38;  // '8'
    localparam logic [CH_W-1:0] CH_X     = 8'h78;  // 'x'
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [CH_W-1:0] HEX_TEN  = 8'd10;

    typedef enum logic [1:0] {
        RADIX_TEN     = 2'd0,
        RADIX_EIGHT   = 2'd1,
        RADIX_SIXTEEN = 2'd2
    } radix_t;

    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_REST   = 3'b100
    } pos_t;

    typedef struct packed {
        radix_t radix;
        pos_t   pos;
        logic   stopped;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{radix: RADIX_TEN, pos: POS_FIRST, stopped: 1'b0};

endpackage

`default_nettype wire

// File: src/radix_prefix_number_parser_top.sv
// Top level of the radix prefix number parser: stream ports, state and result registers.
// Depends on rpnp_pkg and rpnp_step.
//
//  channel | dir | tdata                 | tlast            | tuser
//  --------+-----+-----------------------+------------------+------
//  s_      | in  | [7:0] ch              | last char of str | -
//  m_      | out | [63:0] value          | -                | -
//
// Timing: one character per clock while s_tready is high; the value is in m_tdata in the cycle
//   after the transaction that carries tlast.
// The prefix decode, digit decode and one shift-add into the accumulator set the
//   per-cycle path; a multiply by ten is two shifts and a three-input add.
// Reset: rst_n low clears radix, position, stop flag, accumulator and m_tvalid.
// Stalls: s_tready drops only while a result waits and m_tready is low.
`default_nettype none

module radix_prefix_number_parser_top
    import rpnp_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [CH_W-1:0]    s_tdata,    // [7:0] ch
    input  wire logic               s_tlast,    // last character of the string

    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [VALUE_W-1:0]      m_tdata     // [63:0] value
);

    ctl_t               ctl_reg;
    ctl_t               ctl_next;
    ctl_t               ctl_step;
    logic [WIDTH-1:0]   acc_reg;
    logic [WIDTH-1:0]   acc_next;
    logic [WIDTH-1:0]   acc_step;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [VALUE_W-1:0] m_tdata_reg;
    logic               s_accept;

    // result slot is free, or it is drained in this same cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    rpnp_step #(
        .WIDTH (WIDTH)
    ) u_step (
        .ch      (s_tdata),
        .ctl     (ctl_reg),
        .acc     (acc_reg),
        .ctl_out (ctl_step),
        .acc_out (acc_step)
    );

    always_comb
    begin
        ctl_next      = ctl_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (s_accept)
        begin
            if (s_tlast)
            begin
                // string done: hand off the value, start the next string fresh
                ctl_next      = CTL_RESET;
                acc_next      = '0;
                m_tvalid_next = 1'b1;
            end
            else
            begin
                ctl_next = ctl_step;
                acc_next = acc_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg      <= CTL_RESET;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg      <= ctl_next;
            acc_reg      <= acc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded only on the closing transaction
    always_ff @(posedge clk)
    begin
        if (s_accept && s_tlast)
            m_tdata_reg <= VALUE_W'(acc_step);
    end

    // a closing transaction always leaves a result waiting
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tlast |=> m_tvalid)
        else $error("result missing after last transaction");

    // a closing transaction returns the parser to its start state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tlast |=> (ctl_reg.pos == POS_FIRST) && (acc_reg == '0)
                                && !ctl_reg.stopped)
        else $error("state not cleared after last transaction");

    // at the start of a string nothing has been taken yet
    a_first_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.pos == POS_FIRST |-> (acc_reg == '0) && !ctl_reg.stopped
                                     && (ctl_reg.radix == RADIX_TEN))
        else $error("dirty state at first character");

    // base sixteen is only reached through the two-character prefix
    a_hex_after_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.radix == RADIX_SIXTEEN |-> ctl_reg.pos == POS_REST)
        else $error("hex radix before prefix complete");

endmodule

`default_nettype wire

// File: src/rpnp_step.sv
// Next-state logic for one character: prefix handling, digit decode, accumulate.
// Depends on rpnp_pkg.
`default_nettype none

module rpnp_step
    import rpnp_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  wire logic [CH_W-1:0]  ch,
    input  wire ctl_t             ctl,
    input  wire logic [WIDTH-1:0] acc,
    output ctl_t                  ctl_out,
    output logic [WIDTH-1:0]      acc_out
);

    logic             is_dec;
    logic             is_upper;
    logic             is_lower;
    logic             hex_letter;
    logic [CH_W-1:0]  digit_wide;
    logic [3:0]       digit;
    logic [WIDTH-1:0] digit_ext;
    radix_t           radix_eff;
    ctl_t             ctl_pre;
    logic             do_digit;
    logic             stop_now;
    logic [WIDTH-1:0] acc_mac;

    always_comb
    begin
        is_dec     = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_upper   = (ch >= CH_UA) && (ch <= CH_UF);
        is_lower   = (ch >= CH_LA) && (ch <= CH_LF);
        hex_letter = is_upper || is_lower;

        priority if (is_dec)
            digit_wide = ch - CH_ZERO;
        else if (is_upper)
            digit_wide = ch - CH_UA + HEX_TEN;
        else
            digit_wide = ch - CH_LA + HEX_TEN;
        digit     = digit_wide[3:0];
        digit_ext = WIDTH'(digit);
    end

    // prefix handling picks the radix in force and whether a digit is taken
    always_comb
    begin
        ctl_pre   = ctl;
        radix_eff = ctl.radix;
        do_digit  = 1'b1;
        unique case (ctl.pos)
            POS_FIRST:
            begin
                if (ch == CH_ZERO)
                begin
                    radix_eff   = RADIX_EIGHT;
                    ctl_pre.pos = POS_SECOND;
                end
                else
                begin
                    radix_eff   = RADIX_TEN;
                    ctl_pre.pos = POS_REST;
                end
            end
            POS_SECOND:
            begin
                ctl_pre.pos = POS_REST;
                if (!ctl.stopped && (ctl.radix == RADIX_EIGHT) && (ch == CH_X))
                begin
                    radix_eff = RADIX_SIXTEEN;
                    do_digit  = 1'b0;
                end
            end
            POS_REST:
            begin
            end
            default:
            begin
                ctl_pre.pos = POS_REST;
            end
        endcase
        ctl_pre.radix = radix_eff;
    end

    // digit validity and multiply-accumulate by shifts and adds
    always_comb
    begin
        unique case (radix_eff)
            RADIX_SIXTEEN:
            begin
                stop_now = !(is_dec || hex_letter);
                acc_mac  = (acc << 4) | digit_ext;
            end
            RADIX_EIGHT:
            begin
                stop_now = hex_letter || (ch >= CH_EIGHT) || !is_dec;
                acc_mac  = (acc << 3) | digit_ext;
            end
            default:
            begin
                stop_now = !is_dec;
                acc_mac  = (acc << 3) + (acc << 1) + digit_ext;
            end
        endcase

        ctl_out = ctl_pre;
        acc_out = acc;
        if (do_digit && !ctl.stopped)
        begin
            if (stop_now)
                ctl_out.stopped = 1'b1;
            else
                acc_out = acc_mac;
        end
    end

endmodule

`default_nettype wire

// File: verif/rpnp_checker.sv
// Scoreboard for the radix prefix number parser: watches both stream channels,
// predicts the parsed value of every string and compares it with m_tdata.
// Depends on rpnp_pkg.
`default_nettype none

module rpnp_checker
    import rpnp_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [CH_W-1:0]    s_tdata,
    input  wire logic               s_tlast,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [VALUE_W-1:0] m_tdata,
    output int                      fail_count,
    output int                      pending,
    output int                      values_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - WIDTH);

    radix_t             radix_q;
    pos_t               pos_q;
    bit                 halted;
    logic [VALUE_W-1:0] acc;
    logic [VALUE_W-1:0] expected_values[$];

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // One character against the current radix; a bad digit halts the parse.
    function automatic void absorb_digit(input logic [CH_W-1:0] c);
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] digit;
        bit                 hex_letter;
        hex_letter = (c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF);
        if (halted)
            return;
        case (radix_q)
            RADIX_SIXTEEN: base = 16;
            RADIX_EIGHT:   base = 8;
            default:       base = 10;
        endcase
        if ((base != 16 && hex_letter) || (base == 8 && c >= CH_EIGHT))
        begin
            halted = 1'b1;
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE)
            digit = VALUE_W'(c - CH_ZERO);
        else if (c >= CH_UA && c <= CH_UF)
            digit = VALUE_W'(c - CH_UA) + VALUE_W'(HEX_TEN);
        else if (c >= CH_LA && c <= CH_LF)
            digit = VALUE_W'(c - CH_LA) + VALUE_W'(HEX_TEN);
        else
        begin
            halted = 1'b1;
            return;
        end
        acc = (acc * base + digit) & VALUE_MASK;
    endfunction

    function automatic void clear_parse();
        radix_q = RADIX_TEN;
        pos_q   = POS_FIRST;
        halted  = 1'b0;
        acc     = '0;
    endfunction

    // Prefix handling: a leading zero picks octal, a following 'x' picks hex.
    function automatic void absorb_char(input logic [CH_W-1:0] c, input logic is_last);
        case (pos_q)
            POS_FIRST:
            begin
                if (c == CH_ZERO)
                begin
                    radix_q = RADIX_EIGHT;
                    pos_q   = POS_SECOND;
                end
                else
                begin
                    radix_q = RADIX_TEN;
                    pos_q   = POS_REST;
                end
                absorb_digit(c);
            end
            POS_SECOND:
            begin
                pos_q = POS_REST;
                if (!halted && radix_q == RADIX_EIGHT && c == CH_X)
                    radix_q = RADIX_SIXTEEN;
                else
                    absorb_digit(c);
            end
            default: absorb_digit(c);
        endcase
        if (is_last)
        begin
            expected_values.push_back(acc & VALUE_MASK);
            clear_parse();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [VALUE_W-1:0] exp_value;
        if (!rst_n)
        begin
            clear_parse();
            expected_values.delete();
            pending <= 0;
        end
        else
        begin
            // Results are checked before this edge's input is absorbed; the
            // value never leaves in the same cycle as its last character.
            if (m_tvalid && m_tready)
            begin
                if (expected_values.size() == 0)
                    report_mismatch($sformatf("unexpected value 0x%h", m_tdata));
                else
                begin
                    exp_value = expected_values.pop_front();
                    values_checked++;
                    if (m_tdata !== exp_value)
                        report_mismatch($sformatf("value got 0x%h expected 0x%h",
                                                  m_tdata, exp_value));
                end
            end
            if (s_tvalid && s_tready)
                absorb_char(s_tdata, s_tlast);
            pending <= expected_values.size();
        end
    end

    initial
    begin
        fail_count     = 0;
        values_checked = 0;
        pending        = 0;
    end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Testbench top for radix_prefix_number_parser_top: clock, reset, character
// stimulus and result back-pressure; rpnp_checker does the prediction.
// Depends on rpnp_pkg, rpnp_checker and the parser RTL.
`default_nettype none

module tb_top
    import rpnp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 9;
    localparam int ITEM_TARGET  = 1950;
    localparam int QUIET_AFTER  = 1700;   // no idling past this many transactions
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [CH_W-1:0]    s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [VALUE_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int values_checked;

    // Knobs for the sender; quiet is also read by the receiver.
    int idle_pct;
    bit quiet;

    int chars_sent;
    int cycle_count;
    int hex_strings;
    int oct_strings;
    int dec_strings;
    int noise_strings;
    int broken_strings;

    always #(CLK_PERIOD / 2) clk = ~clk;

    radix_prefix_number_parser_top #(.WIDTH(64)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [7:0] ch
        .s_tlast  (s_tlast),     // last character of the string
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)      // [63:0] value
    );

    rpnp_checker #(.WIDTH(64)) u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .values_checked (values_checked)
    );

    // Watchdog: a hung handshake or a lost value ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d values outstanding", cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: m_tready drops in bursts of random length; no new burst starts in the quiet tail.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && stall_left == 0 && $urandom_range(0, 99) < 15)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // One character transaction, optionally preceded by an idle burst. Returns
    // at the rising edge where the transaction completes.
    task automatic send_char(input logic [CH_W-1:0] c, input logic is_last);
        int gap;
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= CH_W'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_string(input logic [CH_W-1:0] text[$]);
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        logic [CH_W-1:0] text[$];
        int              kind;
        int              n;
        int              v;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        idle_pct = 0;
        quiet    = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings: prefixes alone, radix switches, early stops.
        idle_pct = 30;
        send_char("0", 1'b1);                               // lone zero
        send_char("0", 1'b0); send_char("x", 1'b1);         // hex prefix only
        send_char("0", 1'b0); send_char("X", 1'b0);         // capital X stops octal
        send_char("7", 1'b1);
        send_char(8'h00, 1'b1);                             // NUL only
        send_char("0", 1'b0); send_char("7", 1'b0);         // hex letter stops octal
        send_char("a", 1'b1);
        send_char("9", 1'b0); send_char("F", 1'b0);         // hex letter stops decimal
        send_char("1", 1'b1);
        send_char("0", 1'b0); send_char("x", 1'b0);         // mixed-case hex
        send_char("a", 1'b0); send_char("F", 1'b1);
        send_char("0", 1'b0); send_char(8'hFF, 1'b0);       // top code stops octal
        send_char("1", 1'b1);
        send_char("x", 1'b0); send_char("5", 1'b1);         // 'x' first is not a prefix

        // Hold off until every directed value is back before going random.
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        while (chars_sent < ITEM_TARGET)
        begin
            text.delete();
            quiet = chars_sent > QUIET_AFTER;
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 20;
                default: idle_pct = 50;
            endcase
            // Most strings are short; one in eight draws a long digit count, which can wrap the value.
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 24) : $urandom_range(0, 8);
            kind = $urandom_range(0, 9);
            if (kind < 3)
            begin
                hex_strings++;
                text.push_back(CH_ZERO);
                text.push_back(CH_X);
                repeat (n)
                begin
                    v = $urandom_range(0, 15);
                    if (v < 10)
                        text.push_back(CH_ZERO + CH_W'(v));
                    else
                        text.push_back(($urandom_range(0, 1) ? CH_LA : CH_UA) + CH_W'(v - 10));
                end
            end
            else if (kind < 5)
            begin
                oct_strings++;
                text.push_back(CH_ZERO);
                repeat (n)
                    text.push_back(CH_ZERO + CH_W'($urandom_range(0, 7)));
            end
            else if (kind < 8)
            begin
                dec_strings++;
                text.push_back(CH_ZERO + CH_W'($urandom_range(1, 9)));
                repeat (n)
                    text.push_back(CH_ZERO + CH_W'($urandom_range(0, 9)));
            end
            else
            begin
                noise_strings++;
                repeat ($urandom_range(1, 6))
                    text.push_back(CH_W'($urandom));
            end
            // A trailing run of arbitrary bytes breaks some well-formed strings.
            if (kind < 8 && $urandom_range(0, 3) == 0)
            begin
                broken_strings++;
                repeat ($urandom_range(1, 3))
                    text.push_back(CH_W'($urandom));
            end
            send_string(text);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d characters sent, %0d values checked, %0d mismatches",
                 chars_sent, values_checked, fail_count);
        $display("random strings: hex %0d, octal %0d, decimal %0d, noise %0d, broken tail %0d",
                 hex_strings, oct_strings, dec_strings, noise_strings, broken_strings);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
src/rpnp_pkg.sv
src/rpnp_step.sv
src/radix_prefix_number_parser_top.sv
verif/rpnp_checker.sv
verif/tb_top.sv
